// ----- design/oaht_pkg.sv -----
// ============================================================================
// oaht_pkg
// Shared types and constants of the open-addressing hash table unit.
// ============================================================================
package oaht_pkg;

    // Slot count; a power of two, so the start slot is the low hash bits.
    localparam int SLOTS = 64;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        CMD_GET   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_DEL   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_TOMB  = 2'd2
    } mark_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] key;
        logic [31:0] key_hash;
        logic [63:0] write_value;
    } req_t;

    typedef struct packed {
        logic        flag;
        logic [63:0] read_value;
        logic        full_res;
    } rsp_t;

    // Slot store write port
    typedef struct packed {
        logic             clear;
        logic             key_en;
        logic             data_en;
        logic             mark_en;
        logic [IDX_W-1:0] addr;
        logic [31:0]      key;
        logic [63:0]      data;
        mark_t            mark;
    } wr_t;

    // Slot store read data
    typedef struct packed {
        logic [31:0] key;
        logic [63:0] data;
        mark_t       mark;
    } rd_t;

endpackage

// ----- design/oaht_store.sv -----
// ============================================================================
// oaht_store
// Slot storage: key, data and mark memories with one registered read port,
// plus per-slot valid bits so that reset and clear empty the table at once.
// ============================================================================
module oaht_store
    import oaht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_addr,
    input  wr_t              wr,
    output rd_t              rd
);

    logic [31:0]      key_mem  [SLOTS];
    logic [63:0]      data_mem [SLOTS];
    mark_t            mark_mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;

    logic [31:0] key_rd_reg;
    logic [63:0] data_rd_reg;
    mark_t       mark_rd_reg;
    logic        valid_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.key_en)
        begin
            key_mem[wr.addr] <= wr.key;
        end
        if (wr.data_en)
        begin
            data_mem[wr.addr] <= wr.data;
        end
        if (wr.mark_en)
        begin
            mark_mem[wr.addr] <= wr.mark;
        end
        key_rd_reg  <= key_mem[rd_addr];
        data_rd_reg <= data_mem[rd_addr];
        mark_rd_reg <= mark_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr.clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.mark_en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            valid_rd_reg <= valid_reg[rd_addr];
        end
    end

    // A slot never marked since the last clear reads as empty
    assign rd.key  = key_rd_reg;
    assign rd.data = data_rd_reg;
    assign rd.mark = valid_rd_reg ? mark_rd_reg : MARK_EMPTY;

endmodule

// ----- design/open_addressing_hash_table_unit.sv -----
// ============================================================================
// open_addressing_hash_table_unit
// Linear-probing hash table with tombstones: get, set, delete and clear.
// ============================================================================
// One request at a time. A clear does no probing.
// Get, set and delete probe between 1 and SLOTS slots: the probe walks the
// slot memory one slot per cycle from key_hash modulo SLOTS until it hits
// the key or an empty slot or has walked every slot, and the single read
// port of the slot memory sets that pace. Results sit in an output register;
// the block stays busy only if that register is still held.
// A set of a new key that would take a fresh slot past three quarters load
// is refused with full_res. Clear and reset empty the table at once.
module open_addressing_hash_table_unit
    import oaht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int LOAD_W = CNT_W + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_PROBE,
        ST_FINISH
    } state_t;

    state_t           state_reg,     state_next;
    req_t             req_reg,       req_next;
    logic [IDX_W-1:0] addr_reg,      addr_next;
    logic [IDX_W-1:0] eval_idx_reg,  eval_idx_next;
    logic [IDX_W-1:0] step_reg,      step_next;
    logic             tomb_seen_reg, tomb_seen_next;
    logic [IDX_W-1:0] tomb_idx_reg,  tomb_idx_next;
    logic             found_reg,     found_next;
    logic             spot_ok_reg,   spot_ok_next;
    logic             fresh_reg,     fresh_next;
    logic [IDX_W-1:0] target_reg,    target_next;
    logic [63:0]      rval_reg,      rval_next;
    logic [CNT_W-1:0] used_reg,      used_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg,       rsp_next;

    wr_t              wr;
    rd_t              rd;
    logic             accept;
    logic             out_free;
    logic [CNT_W-1:0] used_inc;
    logic             over_load;

    oaht_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (addr_reg),
        .wr      (wr),
        .rd      (rd)
    );

    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign used_inc  = used_reg + 1'b1;
    assign over_load = {used_inc, 2'b00} > LOAD_W'(3 * SLOTS);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        addr_next      = addr_reg;
        eval_idx_next  = eval_idx_reg;
        step_next      = step_reg;
        tomb_seen_next = tomb_seen_reg;
        tomb_idx_next  = tomb_idx_reg;
        found_next     = found_reg;
        spot_ok_next   = spot_ok_reg;
        fresh_next     = fresh_reg;
        target_next    = target_reg;
        rval_next      = rval_reg;
        used_next      = used_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        wr         = '0;
        wr.addr    = target_reg;
        wr.key     = req_reg.key;
        wr.data    = req_reg.write_value;
        wr.mark    = MARK_USED;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next       = req;
                    addr_next      = req.key_hash[IDX_W-1:0];
                    tomb_seen_next = 1'b0;
                    state_next     = (req.cmd == CMD_CLEAR) ? ST_FINISH : ST_FILL;
                end
            end

            ST_FILL:
            begin
                // First slot read is in flight; keep the read address running
                addr_next     = addr_reg + 1'b1;
                eval_idx_next = addr_reg;
                step_next     = '0;
                state_next    = ST_PROBE;
            end

            ST_PROBE:
            begin
                addr_next     = addr_reg + 1'b1;
                eval_idx_next = addr_reg;
                step_next     = step_reg + 1'b1;
                case (rd.mark)
                    MARK_EMPTY:
                    begin
                        found_next   = 1'b0;
                        spot_ok_next = 1'b1;
                        fresh_next   = !tomb_seen_reg;
                        target_next  = tomb_seen_reg ? tomb_idx_reg : eval_idx_reg;
                        state_next   = ST_FINISH;
                    end
                    MARK_USED:
                    begin
                        if (rd.key == req_reg.key)
                        begin
                            found_next  = 1'b1;
                            target_next = eval_idx_reg;
                            rval_next   = rd.data;
                            state_next  = ST_FINISH;
                        end
                    end
                    default:
                    begin
                        if (!tomb_seen_reg)
                        begin
                            tomb_seen_next = 1'b1;
                            tomb_idx_next  = eval_idx_reg;
                        end
                    end
                endcase
                // Whole table walked without a match or an empty slot
                if (state_next == ST_PROBE && step_reg == IDX_W'(SLOTS - 1))
                begin
                    found_next   = 1'b0;
                    spot_ok_next = tomb_seen_next;
                    fresh_next   = 1'b0;
                    target_next  = tomb_idx_next;
                    state_next   = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.flag       = 1'b0;
                    rsp_next.read_value = '0;
                    rsp_next.full_res   = 1'b0;
                    case (req_reg.cmd)
                        CMD_GET:
                        begin
                            rsp_next.flag = found_reg;
                            if (found_reg)
                            begin
                                rsp_next.read_value = rval_reg;
                            end
                        end
                        CMD_SET:
                        begin
                            if (found_reg)
                            begin
                                wr.data_en = 1'b1;
                            end
                            else if (!spot_ok_reg || (fresh_reg && over_load))
                            begin
                                rsp_next.full_res = 1'b1;
                            end
                            else
                            begin
                                wr.key_en     = 1'b1;
                                wr.data_en    = 1'b1;
                                wr.mark_en    = 1'b1;
                                rsp_next.flag = 1'b1;
                                if (fresh_reg)
                                begin
                                    used_next = used_inc;
                                end
                            end
                        end
                        CMD_DEL:
                        begin
                            if (found_reg)
                            begin
                                wr.mark_en    = 1'b1;
                                wr.mark       = MARK_TOMB;
                                rsp_next.flag = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            wr.clear      = 1'b1;
                            used_next     = '0;
                            rsp_next.flag = 1'b1;
                        end
                        default:
                        begin
                            rsp_next.flag = 1'b0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            tomb_seen_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
            tomb_seen_reg <= tomb_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        addr_reg     <= addr_next;
        eval_idx_reg <= eval_idx_next;
        step_reg     <= step_next;
        tomb_idx_reg <= tomb_idx_next;
        found_reg    <= found_next;
        spot_ok_reg  <= spot_ok_next;
        fresh_reg    <= fresh_next;
        target_reg   <= target_next;
        rval_reg     <= rval_next;
        rsp_reg      <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb
// Random and directed test of the open-addressing hash table unit.
// ============================================================================
// Requests are drawn from a pool of keys, about half of whose hashes cluster around the
// wrap point of the slot array. This forces long probes, wrap-around and
// tombstone reuse, and it takes the table to its load limit. A scoreboard
// keeps its own copy of the slot array and compares every response, field by
// field, with the oldest expected one. Both sides idle at random. One phase
// holds the response side off for a long stretch so that the unit backs up.
// ============================================================================
module tb;
    import oaht_pkg::*;

    localparam int POOL            = 96;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int LONG_HOLD       = 200;
    localparam int WATCHDOG_LIMIT  = 2000;

    class hash_table_scoreboard;
        logic [31:0] slot_key[SLOTS];
        logic [63:0] slot_data[SLOTS];
        mark_t       slot_mark[SLOTS];
        int          used_count;
        rsp_t        expected_rsp[$];
        int          errors;
        int          n_cmd[4];
        int          n_hit, n_full, n_reuse, n_overwrite, n_removed, peak_used;

        function new();
            foreach (slot_mark[i])
                slot_mark[i] = MARK_EMPTY;
            used_count = 0;
            errors     = 0;
            foreach (n_cmd[i])
                n_cmd[i] = 0;
            n_hit = 0;
            n_full = 0;
            n_reuse = 0;
            n_overwrite = 0;
            n_removed = 0;
            peak_used = 0;
        endfunction

        // Updates the slot array for one command and returns its response.
        function rsp_t apply_command(input req_t r);
            rsp_t res;
            int   idx, hit, tomb, spot, n;
            bit   fresh, stop;
            res = '0;
            n_cmd[r.cmd]++;
            if (r.cmd == CMD_CLEAR)
            begin
                foreach (slot_mark[i])
                    slot_mark[i] = MARK_EMPTY;
                used_count = 0;
                res.flag = 1'b1;
                return res;
            end
            idx   = int'(r.key_hash % 32'(SLOTS));
            hit   = -1;
            tomb  = -1;
            spot  = -1;
            fresh = 1'b0;
            stop  = 1'b0;
            n     = 0;
            while (n < SLOTS && !stop)
            begin
                if (slot_mark[idx] == MARK_EMPTY)
                begin
                    if (tomb >= 0)
                        spot = tomb;
                    else
                    begin
                        spot  = idx;
                        fresh = 1'b1;
                    end
                    stop = 1'b1;
                end
                else if (slot_mark[idx] == MARK_USED)
                begin
                    if (slot_key[idx] == r.key)
                    begin
                        hit  = idx;
                        stop = 1'b1;
                    end
                end
                else if (tomb < 0)
                    tomb = idx;
                if (!stop)
                    idx = (idx + 1) % SLOTS;
                n++;
            end
            // probe ran through every slot without an empty one
            if (hit < 0 && spot < 0)
                spot = tomb;

            case (r.cmd)
                CMD_GET:
                begin
                    if (hit >= 0)
                    begin
                        res.flag       = 1'b1;
                        res.read_value = slot_data[hit];
                        n_hit++;
                    end
                end
                CMD_DEL:
                begin
                    if (hit >= 0)
                    begin
                        slot_mark[hit] = MARK_TOMB;
                        res.flag = 1'b1;
                        n_removed++;
                    end
                end
                default:
                begin
                    if (hit >= 0)
                    begin
                        slot_data[hit] = r.write_value;
                        n_overwrite++;
                    end
                    else if (spot < 0 || (fresh && 4 * (used_count + 1) > 3 * SLOTS))
                    begin
                        res.full_res = 1'b1;
                        n_full++;
                    end
                    else
                    begin
                        if (fresh)
                            used_count++;
                        else
                            n_reuse++;
                        slot_key[spot]  = r.key;
                        slot_data[spot] = r.write_value;
                        slot_mark[spot] = MARK_USED;
                        res.flag = 1'b1;
                    end
                end
            endcase
            if (used_count > peak_used)
                peak_used = used_count;
            return res;
        endfunction

        function void note_request(input req_t r);
            expected_rsp.push_back(apply_command(r));
        endfunction

        function void check_response(input rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                $error("response with no request outstanding");
                errors++;
                return;
            end
            want = expected_rsp.pop_front();
            if (got.flag !== want.flag)
            begin
                $error("flag: expected %0b, got %0b", want.flag, got.flag);
                errors++;
            end
            if (got.read_value !== want.read_value)
            begin
                $error("read_value: expected %h, got %h", want.read_value, got.read_value);
                errors++;
            end
            if (got.full_res !== want.full_res)
            begin
                $error("full_res: expected %0b, got %0b", want.full_res, got.full_res);
                errors++;
            end
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    hash_table_scoreboard sb = new();

    logic [31:0] key_pool[POOL];
    logic [31:0] hash_pool[POOL];
    bit          calm             = 1'b0;
    bit          hold_off_pending = 1'b0;

    open_addressing_hash_table_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
            if (req_valid && !req_stall)
                sb.note_request(req);
        end
    end

    // Mostly no gap, some short ones, a few long ones; none in the calm phase.
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic req_t make_request(input cmd_t c, input logic [31:0] k,
                                          input logic [31:0] h, input logic [63:0] v);
        req_t r;
        r.cmd         = c;
        r.key         = k;
        r.key_hash    = h;
        r.write_value = v;
        return r;
    endfunction

    // About half the hashes start near the wrap point, so probes collide and wrap.
    task automatic renew_key_pool();
        logic [31:0] h;
        for (int p = 0; p < POOL; p++)
        begin
            key_pool[p] = $urandom;
            h = $urandom;
            if ($urandom_range(0, 1))
                h[IDX_W-1:0] = IDX_W'(SLOTS - 4 + $urandom_range(0, 7));
            hash_pool[p] = h;
        end
    endtask

    function automatic req_t random_request(input bit filling);
        req_t r;
        int   p, roll;
        p = $urandom_range(0, POOL - 1);
        r.key         = key_pool[p];
        r.key_hash    = hash_pool[p];
        r.write_value = {$urandom, $urandom};
        roll = $urandom_range(0, 999);
        if (roll < 4)
            r.cmd = CMD_CLEAR;
        else if (roll < (filling ? 650 : 400))
            r.cmd = CMD_SET;
        else if (roll < (filling ? 850 : 700))
            r.cmd = CMD_GET;
        else
            r.cmd = CMD_DEL;
        // noise: key seen under a foreign hash, or a key not in the pool
        if ($urandom_range(0, 9) == 0)
        begin
            if ($urandom_range(0, 1))
                r.key = $urandom;
            else
                r.key_hash = $urandom;
        end
        return r;
    endfunction

    task automatic send_request(input req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Response side
    initial
    begin
        int len;
        forever
        begin
            @(posedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else
            begin
                len = pick_gap();
                if (len > 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (len) @(posedge clk);
                    rsp_stall <= 1'b0;
                end
            end
        end
    end

    // Watchdog: cycles in a row with no request or response moving
    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle = 0;
            else
                idle++;
        end
        $error("no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: misses, extreme keys and values, key zero, overwrite,
        // delete, tombstone reuse, probe wrapping past the last slot, clear
        send_request(make_request(CMD_CLEAR, 32'd1, 32'd0, 64'd0));
        send_request(make_request(CMD_GET, 32'd1, 32'd0, 64'd0));
        send_request(make_request(CMD_DEL, 32'd1, 32'd0, 64'd0));
        send_request(make_request(CMD_SET, 32'd1, 32'd0, '1));
        send_request(make_request(CMD_SET, '1, '1, 64'd0));
        send_request(make_request(CMD_SET, 32'd0, 32'(SLOTS), {32{2'b01}}));
        send_request(make_request(CMD_GET, 32'd0, 32'(SLOTS), 64'd0));
        send_request(make_request(CMD_SET, 32'd1, 32'd0, {32{2'b10}}));
        send_request(make_request(CMD_GET, 32'd1, 32'd0, '1));
        send_request(make_request(CMD_DEL, 32'd1, 32'd0, 64'd0));
        send_request(make_request(CMD_GET, 32'd0, 32'(SLOTS), 64'd0));
        send_request(make_request(CMD_SET, 32'd7, 32'h7FFF_FFC0, 64'h0123_4567_89AB_CDEF));
        send_request(make_request(CMD_SET, 32'd9, 32'(SLOTS - 1), 64'hFEDC_BA98_7654_3210));
        send_request(make_request(CMD_GET, 32'd9, 32'(SLOTS - 1), 64'd0));
        send_request(make_request(CMD_GET, '1, '1, 64'd0));
        send_request(make_request(CMD_DEL, 32'd9, 32'(4 * SLOTS - 1), 64'd0));
        send_request(make_request(CMD_SET, 32'd9, 32'(SLOTS - 1), 64'd5));
        send_request(make_request(CMD_GET, 32'd9, 32'(SLOTS - 1), 64'd0));
        send_request(make_request(CMD_GET, 32'd5, 32'h1234_5678, 64'd0));
        send_request(make_request(CMD_CLEAR, '1, '1, '1));
        send_request(make_request(CMD_GET, 32'd0, 32'(SLOTS), 64'd0));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase % 2 == 0)
            begin
                renew_key_pool();
                send_request(make_request(CMD_CLEAR, 32'd1, 32'd0, 64'd0));
            end
            calm = (phase == 2);
            if (phase == 5)
                hold_off_pending = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_request(random_request(phase % 2 == 0));
        end
        req_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SLOTS + 4) @(posedge clk);

        $display("Ran %0d gets (%0d hits), %0d sets (%0d overwrites, %0d into tombstones,",
                 sb.n_cmd[CMD_GET], sb.n_hit, sb.n_cmd[CMD_SET], sb.n_overwrite, sb.n_reuse);
        $display("  %0d refused at load limit), %0d deletes (%0d removed), %0d clears, peak count %0d",
                 sb.n_full, sb.n_cmd[CMD_DEL], sb.n_removed, sb.n_cmd[CMD_CLEAR], sb.peak_used);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
design/oaht_pkg.sv
design/oaht_store.sv
design/open_addressing_hash_table_unit.sv
tb/tb.sv
